/* src/csdi_pkg.sv */
// ----------------------------------------------------------------------------
// csdi_pkg
// Shared widths and constants for the calibrated speed-to-duty interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package csdi_pkg;

  localparam int TABLE_ENTRIES = 385;
  localparam int DUTY_SHIFT    = 2;

  localparam int IDX_W  = 9;
  localparam int SPD_W  = 16;
  localparam int DUTY_W = 11;
  localparam int PROD_W = SPD_W + IDX_W;
  localparam int NUM_W  = PROD_W + DUTY_SHIFT;
  localparam int CNT_W  = $clog2(NUM_W + 1);

  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [DUTY_W-1:0] TOP_DUTY = DUTY_W'((TABLE_ENTRIES - 1) << DUTY_SHIFT);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

endpackage

`default_nettype wire

/* src/csdi_div.sv */
// ----------------------------------------------------------------------------
// csdi_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module csdi_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       go,
  input  wire logic [csdi_pkg::NUM_W-1:0] dividend,
  input  wire logic [csdi_pkg::SPD_W-1:0] divisor,
  output logic                            done,
  output logic [csdi_pkg::NUM_W-1:0]      quotient
);
  import csdi_pkg::*;

  logic             running;
  logic [CNT_W-1:0] cnt;
  logic [SPD_W-1:0] den;
  logic [SPD_W:0]   rem;
  logic [NUM_W-1:0] quo;
  logic [SPD_W:0]   trial;
  logic             fits;

  assign trial    = {rem[SPD_W-1:0], quo[NUM_W-1]};
  assign fits     = trial >= {1'b0, den};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        rem     <= '0;
        quo     <= dividend;
        den     <= divisor;
        cnt     <= CNT_W'(NUM_W);
        running <= 1'b1;
      end else if (running) begin
        rem <= fits ? (trial - {1'b0, den}) : trial;
        quo <= {quo[NUM_W-2:0], fits};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* src/calibrated_speed_to_duty_interpolator.sv */
// ----------------------------------------------------------------------------
// calibrated_speed_to_duty_interpolator
// Calibration table in one synchronous RAM; a query scans it for the nearest
// calibrated speed, walks past flat neighbours and interpolates the duty.
//
//   channel  | handshake          | words
//   ---------+--------------------+------------------------------------------
//   command  | start && !busy     | opcode, entry_index, entry_speed,
//            |                    | query_speed
//   result   | done (one cycle)   | duty, anchor_index, below_start,
//            |                    | interpolated
//
// After reset a clearing pass zeroes the RAM with busy high.
// A write takes its accept cycle only; busy stays low.
// A query scans every table entry, walks past each flat neighbour with its
// own read of the single RAM read port, then multiplies and divides.
// The result shows for one cycle; busy drops in that same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module calibrated_speed_to_duty_interpolator (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        opcode,
  input  wire logic [csdi_pkg::IDX_W-1:0]  entry_index,
  input  wire logic [csdi_pkg::SPD_W-1:0]  entry_speed,
  input  wire logic [csdi_pkg::SPD_W-1:0]  query_speed,
  output logic                             done,
  output logic [csdi_pkg::DUTY_W-1:0]      duty,
  output logic [csdi_pkg::IDX_W-1:0]       anchor_index,
  output logic                             below_start,
  output logic                             interpolated
);
  import csdi_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_SCAN_END,
    S_EVAL,
    S_WALK_STEP,
    S_WALK_CHK,
    S_MUL,
    S_DIV_GO,
    S_DIV_WAIT
  } state_t;

  state_t state;

  logic [SPD_W-1:0] mem [TABLE_ENTRIES];
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [SPD_W-1:0] mem_wdata;
  logic [IDX_W-1:0] rd_addr;
  logic [SPD_W-1:0] rd_data;

  logic [IDX_W-1:0]  cnt;
  logic              pend;
  logic [IDX_W-1:0]  pend_idx;
  logic [SPD_W-1:0]  q;
  logic              have;
  logic [SPD_W-1:0]  start_spd;
  logic [SPD_W-1:0]  best_err;
  logic [SPD_W-1:0]  best_s;
  logic [IDX_W-1:0]  anchor;
  logic              dir_up;
  logic [IDX_W-1:0]  other;
  logic [IDX_W-1:0]  other_next;
  logic [SPD_W-1:0]  v_other;
  logic [PROD_W-1:0] prod;
  logic [SPD_W-1:0]  den_mag;
  logic              den_neg;

  logic [SPD_W-1:0]  err;
  logic [SPD_W-1:0]  qd;
  logic [IDX_W-1:0]  id;
  logic              walk_end;
  logic              div_go;
  logic              div_done;
  logic [NUM_W-1:0]  quot;
  logic [NUM_W:0]    base_w;
  logic [NUM_W:0]    quot_w;
  logic [NUM_W:0]    sum_w;
  logic [DUTY_W-1:0] interp_duty;
  logic [DUTY_W-1:0] anchor_duty;

  assign busy = (state != S_IDLE);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = entry_index;
    mem_wdata = entry_speed;
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = cnt;
      mem_wdata = '0;
    end else if (state == S_IDLE && start && opcode == OP_WRITE &&
                 int'(entry_index) < TABLE_ENTRIES) begin
      mem_we = 1'b1;
    end
  end

  assign other_next = dir_up ? (other + IDX_W'(1)) : (other - IDX_W'(1));
  assign rd_addr    = (state == S_WALK_STEP) ? other_next : cnt;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  assign err      = (q > rd_data) ? (q - rd_data) : (rd_data - q);
  assign walk_end = dir_up ? (other == LAST_IDX) : (other == '0);
  assign qd       = dir_up ? (q - best_s) : (best_s - q);
  assign id       = dir_up ? (other - anchor) : (anchor - other);
  assign div_go   = (state == S_DIV_GO);

  csdi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (NUM_W'(prod) << DUTY_SHIFT),
    .divisor  (den_mag),
    .done     (div_done),
    .quotient (quot)
  );

  assign anchor_duty = DUTY_W'(anchor) << DUTY_SHIFT;
  assign base_w      = (NUM_W + 1)'(anchor_duty);
  assign quot_w      = {1'b0, quot};
  assign sum_w       = base_w + quot_w;

  always_comb begin
    if (den_neg) begin
      interp_duty = (quot_w >= base_w) ? '0 : DUTY_W'(base_w - quot_w);
    end else begin
      interp_duty = (sum_w > (NUM_W + 1)'(TOP_DUTY)) ? TOP_DUTY : DUTY_W'(sum_w);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt   <= '0;
      done  <= 1'b0;
      pend  <= 1'b0;
      have  <= 1'b0;
    end else begin
      done <= 1'b0;
      if ((state == S_SCAN || state == S_SCAN_END) && pend && rd_data != '0) begin
        if (!have) begin
          have      <= 1'b1;
          start_spd <= rd_data;
        end
        if (!have || err < best_err) begin
          best_err <= err;
          best_s   <= rd_data;
          anchor   <= pend_idx;
        end
      end
      case (state)
        S_CLEAR: begin
          cnt <= cnt + IDX_W'(1);
          if (cnt == LAST_IDX) begin
            cnt   <= '0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          cnt    <= '0;
          pend   <= 1'b0;
          have   <= 1'b0;
          anchor <= '0;
          if (start && opcode == OP_QUERY) begin
            q     <= query_speed;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          pend     <= 1'b1;
          pend_idx <= cnt;
          if (cnt == LAST_IDX) begin
            state <= S_SCAN_END;
          end else begin
            cnt <= cnt + IDX_W'(1);
          end
        end
        S_SCAN_END: begin
          pend  <= 1'b0;
          state <= S_EVAL;
        end
        S_EVAL: begin
          dir_up <= q > best_s;
          other  <= anchor;
          if (!have || q <= start_spd) begin
            done         <= 1'b1;
            duty         <= '0;
            anchor_index <= '0;
            below_start  <= 1'b1;
            interpolated <= 1'b0;
            state        <= S_IDLE;
          end else if (anchor == '0 || best_s == q) begin
            done         <= 1'b1;
            duty         <= anchor_duty;
            anchor_index <= anchor;
            below_start  <= 1'b0;
            interpolated <= 1'b0;
            state        <= S_IDLE;
          end else begin
            state <= S_WALK_STEP;
          end
        end
        S_WALK_STEP: begin
          if (walk_end) begin
            done         <= 1'b1;
            duty         <= anchor_duty;
            anchor_index <= anchor;
            below_start  <= 1'b0;
            interpolated <= 1'b0;
            state        <= S_IDLE;
          end else begin
            other <= other_next;
            state <= S_WALK_CHK;
          end
        end
        S_WALK_CHK: begin
          if (rd_data == best_s) begin
            state <= S_WALK_STEP;
          end else if (rd_data == '0) begin
            done         <= 1'b1;
            duty         <= anchor_duty;
            anchor_index <= anchor;
            below_start  <= 1'b0;
            interpolated <= 1'b0;
            state        <= S_IDLE;
          end else begin
            v_other <= rd_data;
            state   <= S_MUL;
          end
        end
        S_MUL: begin
          prod    <= PROD_W'(qd) * PROD_W'(id);
          den_neg <= v_other < best_s;
          den_mag <= (v_other > best_s) ? (v_other - best_s) : (best_s - v_other);
          state   <= S_DIV_GO;
        end
        S_DIV_GO: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            done         <= 1'b1;
            duty         <= interp_duty;
            anchor_index <= anchor;
            below_start  <= 1'b0;
            interpolated <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/csdi_chk.sv */
// ----------------------------------------------------------------------------
// csdi_chk
// Port-level checks for the calibrated speed-to-duty interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

module csdi_chk (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        opcode,
  input wire logic                        done,
  input wire logic [csdi_pkg::DUTY_W-1:0] duty,
  input wire logic [csdi_pkg::IDX_W-1:0]  anchor_index,
  input wire logic                        below_start,
  input wire logic                        interpolated
);
  import csdi_pkg::*;

  a_clear_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low right after reset");

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while busy");

  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    start && !busy && opcode == OP_WRITE |=> !done)
    else $error("write produced a result");

  a_dead_zone: assert property (@(posedge clk) disable iff (rst)
    done && below_start |-> duty == '0 && anchor_index == '0 && !interpolated)
    else $error("dead zone result not zero");

  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    done |-> duty <= TOP_DUTY)
    else $error("duty above table top");

endmodule

bind calibrated_speed_to_duty_interpolator csdi_chk u_csdi_chk (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .opcode       (opcode),
  .done         (done),
  .duty         (duty),
  .anchor_index (anchor_index),
  .below_start  (below_start),
  .interpolated (interpolated)
);

`default_nettype wire

/* tb/tb_calibrated_speed_to_duty_interpolator.sv */
// ----------------------------------------------------------------------------
// tb_calibrated_speed_to_duty_interpolator
// Self-checking bench for the speed-to-duty interpolator. A shadow copy of the
// calibration table tracks every accepted write; each accepted query is turned
// into an expected duty word, and every done strobe is compared against the
// oldest pending word. Stimulus opens with directed corner cases, then runs
// sessions of calibration writes followed by queries near the stored speeds,
// under several sender idle rates.
// ----------------------------------------------------------------------------
module tb_calibrated_speed_to_duty_interpolator;
  import csdi_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int WORDS_PER_PHASE = 225;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic [IDX_W-1:0]  anchor_index;
    logic              below_start;
    logic              interpolated;
  } duty_result_t;

  class duty_checker;
    logic [SPD_W-1:0] speed_table [TABLE_ENTRIES];
    duty_result_t     expected_duties [$];
    int               failures;

    function new();
      foreach (speed_table[i]) speed_table[i] = '0;
      failures = 0;
    endfunction

    function duty_result_t predict_duty(logic [SPD_W-1:0] q_spd);
      duty_result_t r;
      int q, s, err, best_err, anchor, first_spd, other, step, i, top;
      bit found;
      longint d;
      r = '0;
      q = int'(q_spd);
      best_err = 32'h7fffffff;
      anchor = 0;
      first_spd = 0;
      found = 1'b0;
      top = (TABLE_ENTRIES - 1) << DUTY_SHIFT;
      for (i = 0; i < TABLE_ENTRIES; i++) begin
        s = int'(speed_table[i]);
        if (s != 0) begin
          if (!found) begin
            first_spd = s;
            found = 1'b1;
          end
          err = (q > s) ? q - s : s - q;
          if (err < best_err) begin
            best_err = err;
            anchor = i;
          end
        end
      end
      if (!found || q <= first_spd) begin
        r.below_start = 1'b1;
        return r;
      end
      if (anchor == 0) return r;
      r.anchor_index = anchor[IDX_W-1:0];
      d = longint'(anchor) << DUTY_SHIFT;
      s = int'(speed_table[anchor]);
      if (s != q) begin
        step = (q > s) ? 1 : -1;
        other = anchor + step;
        while (other >= 0 && other < TABLE_ENTRIES && speed_table[other] == s)
          other += step;
        if (other >= 0 && other < TABLE_ENTRIES && speed_table[other] != 0) begin
          d = d + (longint'(q - s) * (other - anchor) * (1 << DUTY_SHIFT))
                  / (int'(speed_table[other]) - s);
          if (d < 0) d = 0;
          if (d > top) d = top;
          r.interpolated = 1'b1;
        end
      end
      r.duty = d[DUTY_W-1:0];
      return r;
    endfunction

    function void note_word(op_t op, logic [IDX_W-1:0] idx, logic [SPD_W-1:0] spd,
                            logic [SPD_W-1:0] q_spd);
      if (op == OP_WRITE) begin
        if (idx < TABLE_ENTRIES) speed_table[idx] = spd;
      end else begin
        expected_duties.push_back(predict_duty(q_spd));
      end
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        failures++;
      end
    endfunction

    function void check_result(duty_result_t got);
      duty_result_t want;
      if (expected_duties.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual duty %0d anchor %0d",
                 $time, got.duty, got.anchor_index);
        failures++;
        return;
      end
      want = expected_duties.pop_front();
      compare_field("duty", int'(want.duty), int'(got.duty));
      compare_field("anchor_index", int'(want.anchor_index), int'(got.anchor_index));
      compare_field("below_start", int'(want.below_start), int'(got.below_start));
      compare_field("interpolated", int'(want.interpolated), int'(got.interpolated));
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic              opcode = 1'b0;
  logic [IDX_W-1:0]  entry_index = '0;
  logic [SPD_W-1:0]  entry_speed = '0;
  logic [SPD_W-1:0]  query_speed = '0;
  logic              done;
  logic [DUTY_W-1:0] duty;
  logic [IDX_W-1:0]  anchor_index;
  logic              below_start;
  logic              interpolated;

  duty_checker sb;
  int          idle_pct = 0;
  int          words_sent = 0;
  int          stall_cycles = 0;
  int          written_idx [$];

  calibrated_speed_to_duty_interpolator dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .entry_index  (entry_index),
    .entry_speed  (entry_speed),
    .query_speed  (query_speed),
    .done         (done),
    .duty         (duty),
    .anchor_index (anchor_index),
    .below_start  (below_start),
    .interpolated (interpolated)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(duty_result_t'({duty, anchor_index, below_start, interpolated}));
      if (start && !busy) sb.note_word(op_t'(opcode), entry_index, entry_speed, query_speed);
      if (done || (start && !busy)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // call at a falling edge; returns at the falling edge after the word is taken
  task automatic send_word(op_t op, logic [IDX_W-1:0] idx, logic [SPD_W-1:0] spd,
                           logic [SPD_W-1:0] q_spd);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start       <= 1'b1;
    opcode      <= op;
    entry_index <= idx;
    entry_speed <= spd;
    query_speed <= q_spd;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op == OP_QUERY || idx < TABLE_ENTRIES) words_sent++;
    @(negedge clk);
  endtask

  task automatic write_entry(int idx, int spd);
    send_word(OP_WRITE, IDX_W'(idx), SPD_W'(spd), SPD_W'($urandom_range(0, 65535)));
    if (idx < TABLE_ENTRIES && spd != 0) written_idx.push_back(idx);
  endtask

  task automatic query(int q_spd);
    send_word(OP_QUERY, IDX_W'($urandom_range(0, 511)), SPD_W'($urandom_range(0, 65535)),
              SPD_W'(q_spd));
  endtask

  task automatic run_session();
    int n, k, i, idx, spd, base, slope, run, q, s, s2;
    bit shaped;
    shaped = ($urandom_range(0, 99) < 75);
    if (written_idx.size() > 24 || (shaped && $urandom_range(0, 99) < 60)) begin
      while (written_idx.size() > 0) begin
        idx = written_idx.pop_back();
        send_word(OP_WRITE, IDX_W'(idx), '0, SPD_W'($urandom_range(0, 65535)));
      end
    end
    n = $urandom_range(1, 8);
    base = $urandom_range(1, 4000);
    slope = $urandom_range(1, 190);
    for (k = 0; k < n; k++) begin
      if (shaped) begin
        case ($urandom_range(0, 9))
          0:       idx = 0;
          1:       idx = int'(LAST_IDX);
          2:       idx = $urandom_range(0, 15);
          default: idx = $urandom_range(0, TABLE_ENTRIES - 1);
        endcase
        spd = base + idx * slope + $urandom_range(0, slope / 2);
        if (spd > 65535) spd = 65535;
        run = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 6) : 1;
        for (i = 0; i < run && idx + i < TABLE_ENTRIES; i++) write_entry(idx + i, spd);
      end else begin
        spd = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 65535);
        write_entry($urandom_range(0, 511), spd);
      end
    end
    n = $urandom_range(2, 7);
    for (k = 0; k < n; k++) begin
      if (written_idx.size() > 0) begin
        s  = int'(sb.speed_table[written_idx[$urandom_range(0, written_idx.size() - 1)]]);
        s2 = int'(sb.speed_table[written_idx[$urandom_range(0, written_idx.size() - 1)]]);
      end else begin
        s  = $urandom_range(0, 65535);
        s2 = $urandom_range(0, 65535);
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: q = s + $urandom_range(0, 400) - 200;
        4, 5:       q = s;
        6:          q = (s + s2) / 2;
        7:          q = ($urandom_range(0, 1) == 0) ? 0 : 65535;
        default:    q = $urandom_range(0, 65535);
      endcase
      if (q < 0) q = 0;
      if (q > 65535) q = 65535;
      query(q);
    end
  endtask

  initial begin
    int idle_plan [4];
    int goal;
    sb = new();
    idle_plan = '{0, 51, 0, 8};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    query(0);
    query(65535);
    write_entry(0, 100);
    query(100);
    query(200);
    write_entry(int'(LAST_IDX), 65535);
    write_entry(511, 12345);
    write_entry(TABLE_ENTRIES, 1);
    query(65535);
    query(60000);
    write_entry(10, 1000);
    write_entry(11, 1000);
    write_entry(12, 1000);
    write_entry(13, 2000);
    query(1200);
    query(900);
    query(1800);
    write_entry(13, 0);
    query(1200);
    query(550);

    foreach (idle_plan[p]) begin
      idle_pct = idle_plan[p];
      goal = words_sent + WORDS_PER_PHASE;
      while (words_sent < goal) run_session();
    end
    start <= 1'b0;

    while (sb.expected_duties.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.failures == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule

/* filelist.f */
src/csdi_pkg.sv
src/csdi_div.sv
src/calibrated_speed_to_duty_interpolator.sv
src/csdi_chk.sv
tb/tb_calibrated_speed_to_duty_interpolator.sv
